>>> hdl/pcns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcns_pkg
// Shared types and constants for the pitch capture to note servo block.
// ----------------------------------------------------------------------------
package pcns_pkg;

  localparam int NOTE_COUNT    = 7;
  localparam int NOTES_DEFINED = 7;
  localparam int BANDS_USED    = (NOTE_COUNT > NOTES_DEFINED) ? NOTES_DEFINED :
                                 ((NOTE_COUNT < 1) ? 1 : NOTE_COUNT);
  localparam int HOLES         = 7;
  localparam int NOTE_W        = 3;
  localparam int FREQ_W        = 27;
  localparam int TOL_W         = 10;
  localparam int EXTRA_W       = 12;
  localparam int POS_W         = 10;
  localparam int BAND_W        = 13;
  localparam int APB_ADDR_W    = 5;
  localparam int APB_DATA_W    = 32;

  localparam logic [NOTE_W-1:0] LAST_BAND      = NOTE_W'(BANDS_USED - 1);
  localparam logic [HOLES-1:0]  FRONT_ROW_MASK = 7'h2b;

  typedef enum logic [2:0] {
    REG_REF_CLOCK   = 3'd0,
    REG_TOL_BELOW   = 3'd1,
    REG_TOL_ABOVE   = 3'd2,
    REG_TOP_EXTRA   = 3'd3,
    REG_FRONT_CLOSE = 3'd4,
    REG_FRONT_OPEN  = 3'd5,
    REG_BACK_CLOSE  = 3'd6,
    REG_BACK_OPEN   = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [FREQ_W-1:0]  ref_clock;
    logic [TOL_W-1:0]   tol_below;
    logic [TOL_W-1:0]   tol_above;
    logic [EXTRA_W-1:0] top_extra;
    logic [POS_W-1:0]   front_close;
    logic [POS_W-1:0]   front_open;
    logic [POS_W-1:0]   back_close;
    logic [POS_W-1:0]   back_open;
  } cfg_t;

  function automatic logic [BAND_W-1:0] centre_hz(input logic [NOTE_W-1:0] note);
    logic [BAND_W-1:0] c;
    case (note)
      3'd0:    c = 13'd1500;
      3'd1:    c = 13'd1750;
      3'd2:    c = 13'd1890;
      3'd3:    c = 13'd1975;
      3'd4:    c = 13'd2100;
      3'd5:    c = 13'd2225;
      3'd6:    c = 13'd2325;
      default: c = 13'd1500;
    endcase
    return c;
  endfunction

  // bit h set: hole h closed
  function automatic logic [HOLES-1:0] closed_holes(input logic [NOTE_W-1:0] note);
    logic [HOLES-1:0] m;
    case (note)
      3'd0:    m = 7'h7f;
      3'd1:    m = 7'h3f;
      3'd2:    m = 7'h1f;
      3'd3:    m = 7'h6f;
      3'd4:    m = 7'h07;
      3'd5:    m = 7'h03;
      3'd6:    m = 7'h00;
      default: m = 7'h7f;
    endcase
    return m;
  endfunction

endpackage

>>> hdl/pcns_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcns_regs
// APB register file holding reference clock, band and servo position settings.
// ----------------------------------------------------------------------------
module pcns_regs import pcns_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ref_clock   <= 27'd72000000;
      cfg_q.tol_below   <= 10'd50;
      cfg_q.tol_above   <= 10'd50;
      cfg_q.top_extra   <= 12'd400;
      cfg_q.front_close <= 10'd40;
      cfg_q.front_open  <= 10'd25;
      cfg_q.back_close  <= 10'd25;
      cfg_q.back_open   <= 10'd40;
    end else if (wr_en) begin
      case (idx)
        REG_REF_CLOCK:   cfg_q.ref_clock   <= pwdata[FREQ_W-1:0];
        REG_TOL_BELOW:   cfg_q.tol_below   <= pwdata[TOL_W-1:0];
        REG_TOL_ABOVE:   cfg_q.tol_above   <= pwdata[TOL_W-1:0];
        REG_TOP_EXTRA:   cfg_q.top_extra   <= pwdata[EXTRA_W-1:0];
        REG_FRONT_CLOSE: cfg_q.front_close <= pwdata[POS_W-1:0];
        REG_FRONT_OPEN:  cfg_q.front_open  <= pwdata[POS_W-1:0];
        REG_BACK_CLOSE:  cfg_q.back_close  <= pwdata[POS_W-1:0];
        REG_BACK_OPEN:   cfg_q.back_open   <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_REF_CLOCK:   prdata = APB_DATA_W'(cfg_q.ref_clock);
      REG_TOL_BELOW:   prdata = APB_DATA_W'(cfg_q.tol_below);
      REG_TOL_ABOVE:   prdata = APB_DATA_W'(cfg_q.tol_above);
      REG_TOP_EXTRA:   prdata = APB_DATA_W'(cfg_q.top_extra);
      REG_FRONT_CLOSE: prdata = APB_DATA_W'(cfg_q.front_close);
      REG_FRONT_OPEN:  prdata = APB_DATA_W'(cfg_q.front_open);
      REG_BACK_CLOSE:  prdata = APB_DATA_W'(cfg_q.back_close);
      REG_BACK_OPEN:   prdata = APB_DATA_W'(cfg_q.back_open);
      default:         prdata = '0;
    endcase
  end

endmodule

>>> hdl/pcns_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcns_div
// Restoring divider, one quotient bit per cycle through a shared subtractor.
// ----------------------------------------------------------------------------
module pcns_div import pcns_pkg::*; #(
  parameter int DIVISOR_W = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [FREQ_W-1:0]    dividend_i,
  input  logic [DIVISOR_W-1:0] divisor_i,
  output logic                 done_o,
  output logic [FREQ_W-1:0]    quotient_o
);

  localparam int CNT_W = $clog2(FREQ_W + 1);

  logic                 busy_q;
  logic                 done_q;
  logic [CNT_W-1:0]     cnt_q;
  logic [DIVISOR_W-1:0] rem_q;
  logic [DIVISOR_W-1:0] rem_d;
  logic [DIVISOR_W-1:0] divisor_q;
  logic [FREQ_W-1:0]    quo_q;
  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   rem_sub;
  logic                 ge;

  always_comb begin
    rem_sh  = {rem_q, quo_q[FREQ_W-1]};
    rem_sub = rem_sh - {1'b0, divisor_q};
    ge      = (rem_sh >= {1'b0, divisor_q});
    rem_d   = ge ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q & ~start_i & (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(FREQ_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q     <= dividend_i;
      rem_q     <= '0;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[FREQ_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

>>> hdl/pitch_capture_to_note_servos_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pitch_capture_to_note_servos_top
// Period from capture pairs, iterative frequency divide, note band scan and
// servo position lookup.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  input     in         in_valid_i / in_stall_o    capture_value_i
//  output    out        out_valid_o / out_stall_i  note_index_o, measured_freq_o,
//                                                  band_hit_o, servo_0_o..servo_6_o
//  config    in         psel/penable/pwrite/pready paddr, pwdata, prdata
//
//  first word of a pair: stored as the first edge, no result
//  second word: the bit-serial divider forms 27 quotient bits and raises done,
//  then one band is tested per cycle (1 to 7), then the output register is loaded
//  once it is free to take the result
//  zero period skips the divider and band scan and goes straight to the output load
//  in_stall_o is high from the second word until the result is in the output
//  register; a stalled output holds the result and delays the next one only
//  async active-low reset sets all settings, control and output state to defaults
// ----------------------------------------------------------------------------
module pitch_capture_to_note_servos_top import pcns_pkg::*; #(
  parameter int TIMER_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [TIMER_BITS-1:0] capture_value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [NOTE_W-1:0]     note_index_o,
  output logic [FREQ_W-1:0]     measured_freq_o,
  output logic                  band_hit_o,
  output logic [POS_W-1:0]      servo_0_o,
  output logic [POS_W-1:0]      servo_1_o,
  output logic [POS_W-1:0]      servo_2_o,
  output logic [POS_W-1:0]      servo_3_o,
  output logic [POS_W-1:0]      servo_4_o,
  output logic [POS_W-1:0]      servo_5_o,
  output logic [POS_W-1:0]      servo_6_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_BAND,
    ST_EMIT
  } state_e;

  cfg_t                  cfg;
  state_e                state_q;
  logic                  have_first_q;
  logic [TIMER_BITS-1:0] first_edge_q;
  logic [TIMER_BITS-1:0] last_period_q;
  logic [TIMER_BITS-1:0] diff;
  logic [TIMER_BITS-1:0] period_d;
  logic [NOTE_W-1:0]     held_note_q;
  logic [NOTE_W-1:0]     band_q;
  logic                  hit_q;
  logic                  zero_per_q;
  logic                  accept;
  logic                  div_start;
  logic                  div_done;
  logic [FREQ_W-1:0]     quotient;
  logic [BAND_W-1:0]     lo;
  logic [BAND_W-1:0]     hi;
  logic                  match;
  logic                  load_out;
  logic [HOLES-1:0]      closed;
  logic [POS_W-1:0]      servo_d [HOLES];
  logic [POS_W-1:0]      servo_q [HOLES];
  logic                  out_valid_q;
  logic [NOTE_W-1:0]     note_q;
  logic [FREQ_W-1:0]     freq_q;
  logic                  band_hit_q;

  pcns_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pcns_div #(
    .DIVISOR_W (TIMER_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (cfg.ref_clock),
    .divisor_i  (period_d),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i & ~in_stall_o;
  assign diff       = capture_value_i - first_edge_q;
  assign period_d   = (diff != '0) ? diff : last_period_q;
  assign div_start  = accept & have_first_q & (period_d != '0);
  assign load_out   = (state_q == ST_EMIT) & (~out_valid_q | ~out_stall_i);

  // band edges for the band under test
  always_comb begin
    lo    = centre_hz(band_q) - BAND_W'(cfg.tol_below);
    hi    = centre_hz(band_q) + BAND_W'(cfg.tol_above) +
            ((band_q == LAST_BAND) ? BAND_W'(cfg.top_extra) : '0);
    match = (FREQ_W'(lo) <= quotient) && (quotient <= FREQ_W'(hi));
  end

  always_comb begin
    closed = closed_holes(held_note_q);
    for (int h = 0; h < HOLES; h++) begin
      if (FRONT_ROW_MASK[h]) begin
        servo_d[h] = closed[h] ? cfg.front_close : cfg.front_open;
      end else begin
        servo_d[h] = closed[h] ? cfg.back_close : cfg.back_open;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !have_first_q) begin
      first_edge_q <= capture_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      have_first_q  <= 1'b0;
      last_period_q <= '0;
      held_note_q   <= '0;
      band_q        <= '0;
      hit_q         <= 1'b0;
      zero_per_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      note_q        <= '0;
      freq_q        <= '0;
      band_hit_q    <= 1'b0;
      for (int h = 0; h < HOLES; h++) begin
        servo_q[h] <= '0;
      end
    end else begin
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            have_first_q <= ~have_first_q;
            if (have_first_q) begin
              last_period_q <= period_d;
              band_q        <= '0;
              hit_q         <= 1'b0;
              zero_per_q    <= (period_d == '0);
              state_q       <= (period_d == '0) ? ST_EMIT : ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_q <= ST_BAND;
          end
        end
        ST_BAND: begin
          if (match) begin
            held_note_q <= band_q;
            hit_q       <= 1'b1;
            state_q     <= ST_EMIT;
          end else if (band_q == LAST_BAND) begin
            state_q <= ST_EMIT;
          end else begin
            band_q <= band_q + NOTE_W'(1);
          end
        end
        ST_EMIT: begin
          if (load_out) begin
            note_q      <= held_note_q;
            freq_q      <= zero_per_q ? '0 : quotient;
            band_hit_q  <= hit_q;
            for (int h = 0; h < HOLES; h++) begin
              servo_q[h] <= servo_d[h];
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign note_index_o    = note_q;
  assign measured_freq_o = freq_q;
  assign band_hit_o      = band_hit_q;
  assign servo_0_o       = servo_q[0];
  assign servo_1_o       = servo_q[1];
  assign servo_2_o       = servo_q[2];
  assign servo_3_o       = servo_q[3];
  assign servo_4_o       = servo_q[4];
  assign servo_5_o       = servo_q[5];
  assign servo_6_o       = servo_q[6];

endmodule
